FILE: rtl/aes_ctr_stream_crypt_defines.svh
// assertion macros for the aes counter mode stream cipher
// used by the checker file only
`ifndef AES_CTR_STREAM_CRYPT_DEFINES_SVH
`define AES_CTR_STREAM_CRYPT_DEFINES_SVH
// same-cycle implication
`define ACS_ASSERT_NOW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ACS_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/acs_pkg.sv
// shared types, constants and aes functions for the counter mode stream cipher
// no dependencies
package acs_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam logic [3:0] ROUND_LAST = 4'd14;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_KEY0   = 3'd0;
    localparam t_cfg_idx CFG_KEY1   = 3'd1;
    localparam t_cfg_idx CFG_KEY2   = 3'd2;
    localparam t_cfg_idx CFG_KEY3   = 3'd3;
    localparam t_cfg_idx CFG_IV_HI  = 3'd4;
    localparam t_cfg_idx CFG_IV_LO  = 3'd5;
    localparam t_cfg_idx CFG_OFFSET = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_head;

    typedef struct packed {
        logic flush;
        logic start;
        logic take;
    } t_gen_ctl;

    typedef struct packed {
        logic busy;
        logic ok;
    } t_gen_sts;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox_byte(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox_byte(w[31:24]), sbox_byte(w[23:16]), sbox_byte(w[15:8]),
                sbox_byte(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // sub bytes, shift rows and, unless final, mix columns; byte 0 at the top
    function automatic logic [127:0] aes_round(input logic [127:0] v, input logic fin);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   all;
        logic [127:0] res;
        for (int k = 0; k < 16; k++) begin
            s[k] = sbox_byte(v[127 - 8 * k -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = s[i + 4 * ((c + i) % 4)];
            end
        end
        if (!fin) begin
            for (int c = 0; c < 4; c++) begin
                all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                s[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
                s[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
                s[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
                s[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
            end
        end else begin
            for (int k = 0; k < 16; k++) begin
                s[k] = t[k];
            end
        end
        for (int k = 0; k < 16; k++) begin
            res[127 - 8 * k -: 8] = s[k];
        end
        return res;
    endfunction

    // slide the eight-word key window forward by four words
    function automatic logic [255:0] key_advance(input logic [255:0] k, input logic [3:0] r);
        logic [31:0] tmp;
        logic [31:0] n0, n1, n2, n3;
        logic [7:0]  rc;
        rc = 8'(8'h01 << r[3:1]);
        if (!r[0]) begin
            tmp = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h000000};
        end else begin
            tmp = sub_word(k[31:0]);
        end
        n0 = k[255:224] ^ tmp;
        n1 = k[223:192] ^ n0;
        n2 = k[191:160] ^ n1;
        n3 = k[159:128] ^ n2;
        return {k[127:0], n0, n1, n2, n3};
    endfunction

endpackage

FILE: rtl/acs_if.sv
// stream channel interfaces for input and result words
// no dependencies
interface acs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface acs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/acs_front.sv
// front end: accepts input words into a short queue
// depends on acs_pkg and acs_in_if
module acs_front
    import acs_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    acs_in_if.sink i_in,
    output t_head o_head,
    input  logic  i_pop
);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [8:0]       r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign i_in.ready = (r_cnt != CNT_W'(FIFO_DEPTH));
    assign push = i_in.valid && i_in.ready;
    assign pop = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.data = r_mem[r_rd][8:1];
    assign o_head.last = r_mem[r_rd][0];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= {i_in.data_byte, i_in.last_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

FILE: rtl/acs_aes_core.sv
// iterative aes-256 encryption, one round per cycle, key schedule on the fly
// depends on acs_pkg
module acs_aes_core
    import acs_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_gen_ctl       i_ctl,
    input  logic [127:0]   i_ctr,
    input  logic [255:0]   i_key,
    output t_gen_sts       o_sts,
    output logic [127:0]   o_block
);
    logic         r_busy;
    logic         r_ok;
    logic [3:0]   r_round;
    logic [127:0] r_s;
    logic [255:0] r_k;

    assign o_sts.busy = r_busy;
    assign o_sts.ok = r_ok;
    assign o_block = r_s;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_s <= i_ctr ^ i_key[255:128];
            r_k <= key_advance(i_key, 4'd0);
        end else if (r_busy) begin
            r_s <= aes_round(r_s, r_round == ROUND_LAST) ^ r_k[255:128];
            r_k <= key_advance(r_k, r_round);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ok <= 1'b0;
            r_round <= '0;
        end else if (i_ctl.flush) begin
            r_busy <= 1'b0;
            r_ok <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_round <= 4'd1;
            end else if (r_busy) begin
                r_round <= r_round + 1'b1;
                if (r_round == ROUND_LAST) begin
                    r_busy <= 1'b0;
                    r_ok <= 1'b1;
                end
            end
            if (i_ctl.take) begin
                r_ok <= 1'b0;
            end
        end
    end
endmodule

FILE: rtl/acs_back.sv
// back end: counter control, keystream block hold and result register
// depends on acs_pkg and acs_out_if
module acs_back
    import acs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_head         i_head,
    output logic          o_pop,
    input  logic [63:0]   i_iv_high,
    input  logic [63:0]   i_iv_low,
    input  logic [47:0]   i_offset,
    output t_gen_ctl      o_gen_ctl,
    output logic [127:0]  o_gen_ctr,
    input  t_gen_sts      i_gen_sts,
    input  logic [127:0]  i_gen_block,
    acs_out_if.source     o_out
);
    logic         r_active;
    logic         r_ks_ok;
    logic [127:0] r_ks;
    logic [3:0]   r_pos;
    logic [127:0] r_ctr;
    logic         r_out_valid;
    logic [7:0]   r_out_byte;
    logic         r_out_last;

    logic       out_free;
    logic       consume;
    logic       start_msg;
    logic       wrap;
    logic       load;
    logic       gen_start;
    logic [7:0] ks_sel;

    assign out_free = !r_out_valid || o_out.ready;
    assign consume = r_active && r_ks_ok && i_head.valid && out_free;
    assign start_msg = !r_active && i_head.valid;
    assign wrap = consume && (r_pos == 4'(BLOCK_BYTES - 1)) && !i_head.last;
    assign load = r_active && i_gen_sts.ok && (!r_ks_ok || wrap);
    assign gen_start = r_active && !i_gen_sts.busy && !i_gen_sts.ok;
    assign ks_sel = r_ks[{~r_pos, 3'b000} +: 8];

    assign o_pop = consume;
    assign o_gen_ctl.flush = start_msg;
    assign o_gen_ctl.start = gen_start;
    assign o_gen_ctl.take = load;
    assign o_gen_ctr = r_ctr;

    assign o_out.valid = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.out_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (start_msg) begin
            r_ctr <= {i_iv_high, i_iv_low} + {84'd0, i_offset[47:4]};
        end else if (gen_start) begin
            r_ctr <= r_ctr + 128'd1;
        end
        if (load) begin
            r_ks <= i_gen_block;
        end
        if (consume) begin
            r_out_byte <= i_head.data ^ ks_sel;
            r_out_last <= i_head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ks_ok <= 1'b0;
            r_pos <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (start_msg) begin
                r_active <= 1'b1;
                r_ks_ok <= 1'b0;
                r_pos <= i_offset[3:0];
            end else begin
                if (consume) begin
                    r_pos <= r_pos + 1'b1;
                    if (i_head.last) begin
                        r_active <= 1'b0;
                    end
                end
                if (load) begin
                    r_ks_ok <= 1'b1;
                end else if (wrap) begin
                    r_ks_ok <= 1'b0;
                end
            end
            if (consume) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

FILE: rtl/aes_ctr_stream_crypt.sv
// path: an accepted word passes the queue, then the result register; the first word
// of a message waits for its keystream block
// throughput: one word per cycle once the next block is ready, unless the output stalls;
// the round loop works one block ahead, but the second block of a message can hold words
// reset: synchronous active low; clears config, queue and control, no clearing pass
module aes_ctr_stream_crypt
    import acs_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acs_in_if.sink      i_in,
    acs_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    logic [63:0] r_key0;
    logic [63:0] r_key1;
    logic [63:0] r_key2;
    logic [63:0] r_key3;
    logic [63:0] r_iv_high;
    logic [63:0] r_iv_low;
    logic [47:0] r_offset;

    t_head        head;
    logic         pop;
    t_gen_ctl     gen_ctl;
    t_gen_sts     gen_sts;
    logic [127:0] gen_ctr;
    logic [127:0] gen_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
            r_iv_high <= '0;
            r_iv_low <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY0: r_key0 <= i_cfg_data;
                CFG_KEY1: r_key1 <= i_cfg_data;
                CFG_KEY2: r_key2 <= i_cfg_data;
                CFG_KEY3: r_key3 <= i_cfg_data;
                CFG_IV_HI: r_iv_high <= i_cfg_data;
                CFG_IV_LO: r_iv_low <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    acs_front #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(i_in),
        .o_head(head),
        .i_pop(pop)
    );

    acs_aes_core u_aes (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl(gen_ctl),
        .i_ctr(gen_ctr),
        .i_key({r_key0, r_key1, r_key2, r_key3}),
        .o_sts(gen_sts),
        .o_block(gen_block)
    );

    acs_back u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_head(head),
        .o_pop(pop),
        .i_iv_high(r_iv_high),
        .i_iv_low(r_iv_low),
        .i_offset(r_offset),
        .o_gen_ctl(gen_ctl),
        .o_gen_ctr(gen_ctr),
        .i_gen_sts(gen_sts),
        .i_gen_block(gen_block),
        .o_out(o_out)
    );
endmodule

FILE: rtl/acs_check.sv
// port-level checks for the stream cipher, bound to the top level
// depends on aes_ctr_stream_crypt_defines.svh
`include "aes_ctr_stream_crypt_defines.svh"
module acs_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);
    `ACS_ASSERT_NOW(a_stall_hold, i_clk, i_rst_n && $past(i_rst_n) && $past(o_out_valid && !i_out_ready), o_out_valid && $stable(o_out_byte) && $stable(o_out_last), "result word changed while stalled")
    `ACS_ASSERT_NEXT(a_reset_out, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")
    `ACS_ASSERT_NEXT(a_reset_ready, i_clk, !i_rst_n, i_in_ready, "input not ready after reset")
endmodule

bind aes_ctr_stream_crypt acs_check u_check (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_in.ready),
    .o_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .o_out_byte(o_out.out_byte),
    .o_out_last(o_out.out_last)
);

FILE: tb/sv/acs_tb_checker.sv
// checker for the aes counter mode stream cipher: watches both channels,
// predicts every result word and compares it; depends on acs_pkg and acs_if
`timescale 1ns / 100ps
module acs_tb_checker
    import acs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    acs_in_if           i_in,
    acs_out_if          i_out,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_cnt,
    output int          o_pending
);

    typedef struct {
        logic [7:0] byte_val;
        logic       last;
    } t_crypt_word;

    logic [63:0]  key_w [4];
    logic [127:0] iv;
    logic [47:0]  offset;
    logic [127:0] ctr;
    logic [7:0]   ks [16];
    logic [3:0]   pos;
    logic         busy_msg;
    t_crypt_word  crypt_q [$];

    function automatic logic [7:0] sb(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [31:0] sw(input logic [31:0] w);
        return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    task automatic make_keystream();
        logic [31:0] w [60];
        logic [31:0] tmp;
        logic [7:0]  s [16];
        logic [7:0]  t [16];
        logic [7:0]  rc;
        logic [7:0]  a0, a1, a2, a3, al;
        for (int i = 0; i < 8; i++) begin
            w[i] = key_w[i / 2][(i % 2) ? 31 : 63 -: 32];
        end
        for (int i = 8; i < 60; i++) begin
            tmp = w[i - 1];
            rc = 8'h01 << ((i / 8) - 1);
            if (i % 8 == 0) begin
                tmp = sw({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
            end else if (i % 8 == 4) begin
                tmp = sw(tmp);
            end
            w[i] = w[i - 8] ^ tmp;
        end
        for (int i = 0; i < 16; i++) begin
            s[i] = ctr[127 - 8 * i -: 8];
        end
        for (int r = 0; r <= 14; r++) begin
            if (r > 0) begin
                for (int i = 0; i < 16; i++) begin
                    s[i] = sb(s[i]);
                end
                for (int c = 0; c < 4; c++) begin
                    for (int i = 0; i < 4; i++) begin
                        t[i + 4 * c] = s[i + 4 * ((c + i) % 4)];
                    end
                end
                s = t;
                if (r < 14) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                        s[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                        s[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                        s[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) begin
                    s[4*c+i] ^= w[4*r+c][31 - 8 * i -: 8];
                end
            end
        end
        ks = s;
    endtask

    task automatic predict_word(input logic [7:0] d, input logic l);
        t_crypt_word e;
        if (!busy_msg) begin
            ctr = iv + 128'(offset[47:4]);
            pos = offset[3:0];
            make_keystream();
            busy_msg = 1'b1;
        end
        e.byte_val = d ^ ks[pos];
        e.last = l;
        crypt_q.push_back(e);
        pos = pos + 4'd1;
        if (l) begin
            busy_msg = 1'b0;
        end else if (pos == 4'd0) begin
            ctr = ctr + 128'd1;
            make_keystream();
        end
    endtask

    assign o_pending = crypt_q.size();

    always @(posedge i_clk) begin
        t_crypt_word e;
        if (!i_rst_n) begin
            key_w = '{default: '0};
            iv = '0;
            offset = '0;
            busy_msg = 1'b0;
            pos = '0;
            crypt_q.delete();
            o_fail_cnt <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (crypt_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h/%b", $time,
                             i_out.out_byte, i_out.out_last);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    e = crypt_q.pop_front();
                    if (e.byte_val !== i_out.out_byte || e.last !== i_out.out_last) begin
                        $display("%0t: mismatch, expected %h/%b, actual %h/%b", $time,
                                 e.byte_val, e.last, i_out.out_byte, i_out.out_last);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_word(i_in.data_byte, i_in.last_byte);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY0: key_w[0] = i_cfg_data;
                    CFG_KEY1: key_w[1] = i_cfg_data;
                    CFG_KEY2: key_w[2] = i_cfg_data;
                    CFG_KEY3: key_w[3] = i_cfg_data;
                    CFG_IV_HI: iv[127:64] = i_cfg_data;
                    CFG_IV_LO: iv[63:0] = i_cfg_data;
                    CFG_OFFSET: offset = i_cfg_data[47:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// top of the aes counter mode stream cipher bench: clock, reset, config phases
// and byte stimulus; depends on acs_pkg, acs_if, the block and acs_tb_checker
`timescale 1ns / 100ps
module testbench;
    import acs_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_idx = CFG_KEY0;
    logic [63:0] cfg_data = '0;
    int          fail_cnt;
    int          pending;
    int          cycle_cnt = 0;

    acs_in_if  in_ch ();
    acs_out_if out_ch ();

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    aes_ctr_stream_crypt i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    acs_tb_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stall per word, with calm stretches
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if ((cycle_cnt / 2000) % 3 == 1) gap = 0;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] d, input logic l);
        int gap;
        gap = ((cycle_cnt / 1500) % 3 == 2) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.last_byte <= l;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_cipher(input logic [63:0] k0, k1, k2, k3, ivh, ivl,
                              input logic [47:0] off);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_IV_HI, ivh);
        write_reg(CFG_IV_LO, ivl);
        write_reg(CFG_OFFSET, {16'h0, off});
    endtask

    initial begin
        int len;
        int sent;
        logic [47:0] off;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero settings from reset
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        drain();
        // counter wrap at all ones, max offset
        set_cipher('1, '1, '1, '1, '1, '1, '1);
        for (int i = 0; i < 20; i++) send_byte(8'(i * 37), i == 19);
        send_byte(8'h5a, 1'b1);
        drain();
        // wrap of the low half only, offset into a block
        set_cipher(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                   64'h18191a1b1c1d1e1f, 64'h0, 64'hffff_ffff_ffff_fffe, 48'd45);
        write_reg(t_cfg_idx'(7), 64'hdead);
        for (int i = 0; i < 20; i++) send_byte(8'($urandom), i == 19);
        drain();

        sent = 0;
        while (sent < 1950) begin
            off = ($urandom_range(0, 3) == 0) ? 48'hffff_ffff_ffff - 48'($urandom_range(0, 40))
                                              : 48'($urandom_range(0, 100));
            set_cipher({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom},
                       ($urandom_range(0, 3) == 0) ? '1 : {$urandom, $urandom},
                       ($urandom_range(0, 3) == 0) ? 64'hffff_ffff_ffff_fff0
                                                   : {$urandom, $urandom}, off);
            for (int m = 0; m < 6; m++) begin
                len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 40);
                for (int i = 0; i < len; i++) begin
                    send_byte(8'($urandom), i == len - 1);
                    sent++;
                end
            end
            drain();
        end

        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
